@@ design/sparse_row_accumulator_assert.svh @@
// Assertion macros for the sparse row accumulator.
`ifndef SPARSE_ROW_ACCUMULATOR_ASSERT_SVH
`define SPARSE_ROW_ACCUMULATOR_ASSERT_SVH

// Check a condition at every clock edge out of reset.
`define SRA_ASSERT_ALWAYS(label, cond) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) \
        else $error("sparse row accumulator check failed");

// Check a consequence at the clock edge that follows its trigger.
`define SRA_ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |=> (post)) \
        else $error("sparse row accumulator check failed");

`endif

@@ design/sra_pkg.sv @@
`default_nettype none
package sra_pkg;

    localparam int CAPACITY  = 32;
    localparam int IDX_W     = $clog2(CAPACITY);
    localparam int CNT_W     = $clog2(CAPACITY + 1);

    localparam int ACTION_W  = 2;
    localparam int ID_W      = 31;
    localparam int ADD_W     = 32;
    localparam int SUM_W     = 40;
    localparam int STATUS_W  = 3;
    localparam int COUNT_W   = 6;

    localparam int S_TDATA_W = 64;
    localparam int S_PAD_W   = S_TDATA_W - ID_W - ADD_W;
    localparam int M_TDATA_W = 120;
    localparam int M_PAD_W   = M_TDATA_W - ID_W - SUM_W - COUNT_W - SUM_W;
    localparam int M_TUSER_W = STATUS_W + 2;

    localparam logic [ACTION_W-1:0] ACT_ADD   = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_RHS   = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_DUMP  = 2'd3;

    localparam logic [STATUS_W-1:0] ST_ACCUM  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_INSERT = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_DONE   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_DUMP   = 3'd4;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
        logic [ID_W-1:0]  id;
        logic [SUM_W-1:0] sum;
    } tbl_wr_t;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
    } tbl_rd_t;

endpackage
`default_nettype wire

@@ design/sra_table.sv @@
`default_nettype none
module sra_table import sra_pkg::*; (
    input  logic             aclk,
    input  tbl_wr_t          wr,
    input  tbl_rd_t          rd,
    output logic [ID_W-1:0]  rd_id_reg,
    output logic [SUM_W-1:0] rd_sum_reg
);

    logic [ID_W-1:0]  id_mem  [CAPACITY];
    logic [SUM_W-1:0] sum_mem [CAPACITY];

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            id_mem[wr.addr]  <= wr.id;
            sum_mem[wr.addr] <= wr.sum;
        end
    end

    // Hold read data while no read is issued.
    always_ff @(posedge aclk) begin
        if (rd.en) begin
            rd_id_reg  <= id_mem[rd.addr];
            rd_sum_reg <= sum_mem[rd.addr];
        end
    end

endmodule
`default_nettype wire

@@ design/sra_satadd.sv @@
`default_nettype none
module sra_satadd import sra_pkg::*; (
    input  logic [SUM_W-1:0] acc,
    input  logic [ADD_W-1:0] addend,
    output logic [SUM_W-1:0] sum,
    output logic             clipped
);

    logic [SUM_W:0] wide;

    always_comb begin
        wide = {acc[SUM_W-1], acc}
             + {{(SUM_W + 1 - ADD_W){addend[ADD_W-1]}}, addend};
        clipped = wide[SUM_W] != wide[SUM_W-1];
        if (!clipped) begin
            sum = wide[SUM_W-1:0];
        end else if (wide[SUM_W]) begin
            sum = {1'b1, {(SUM_W - 1){1'b0}}};
        end else begin
            sum = {1'b0, {(SUM_W - 1){1'b1}}};
        end
    end

endmodule
`default_nettype wire

@@ design/sparse_row_accumulator.sv @@
// Channel  Direction  tdata                                   tuser
// s_       in         column_id, addend                       action
// m_       out        entry_id, entry_sum, entry_count,       status, entry_valid,
//                     rhs_sum                                 saturated; tlast = last
//
// An add reads the stored ids one at a time through the single registered read port,
// compares each with the column id, then updates the matching entry or appends one.
// A dump sends the stored entries, one entry a cycle while the output is not stalled.
// Reset clears the fill count and the rhs sum; the table needs no clearing pass.
// A stalled result holds in the output register; s_tready rises again once the
// result is registered, so a new request is taken while it waits.
`default_nettype none
`include "sparse_row_accumulator_assert.svh"
module sparse_row_accumulator import sra_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,  // column_id[30:0], addend[62:31], zero[63]
    input  logic [ACTION_W-1:0]  s_tuser,  // action[1:0]
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,  // entry_id[30:0], entry_sum[70:31],
                                           // entry_count[76:71], rhs_sum[116:77],
                                           // zero[119:117]
    output logic [M_TUSER_W-1:0] m_tuser,  // status[2:0], entry_valid[3], saturated[4]
    output logic                 m_tlast
);

    localparam logic [2:0] FSM_IDLE   = 3'd0;
    localparam logic [2:0] FSM_SEARCH = 3'd1;
    localparam logic [2:0] FSM_UPDATE = 3'd2;
    localparam logic [2:0] FSM_APPEND = 3'd3;
    localparam logic [2:0] FSM_RHS    = 3'd4;
    localparam logic [2:0] FSM_CLEAR  = 3'd5;
    localparam logic [2:0] FSM_DUMP   = 3'd6;

    logic [2:0]          state_reg, state_next;
    logic [CNT_W-1:0]    fill_reg, fill_next;
    logic [SUM_W-1:0]    rhs_reg, rhs_next;
    logic [CNT_W-1:0]    idx_reg, idx_next;
    logic                pend_reg, pend_next;
    logic [IDX_W-1:0]    pend_idx_reg, pend_idx_next;
    logic [ID_W-1:0]     col_reg;
    logic [ADD_W-1:0]    addend_reg;

    logic                m_valid_reg, m_valid_next;
    logic [STATUS_W-1:0] o_status_reg, o_status_next;
    logic                o_valid_reg, o_valid_next;
    logic [ID_W-1:0]     o_id_reg, o_id_next;
    logic [SUM_W-1:0]    o_sum_reg, o_sum_next;
    logic [COUNT_W-1:0]  o_count_reg, o_count_next;
    logic [SUM_W-1:0]    o_rhs_reg, o_rhs_next;
    logic                o_sat_reg, o_sat_next;
    logic                o_last_reg, o_last_next;

    logic                load;
    logic [STATUS_W-1:0] e_status;
    logic                e_valid;
    logic [ID_W-1:0]     e_id;
    logic [SUM_W-1:0]    e_sum;
    logic                e_sat;
    logic                e_last;

    logic                out_free;
    logic                accept;
    logic                emitting;
    logic                dump_last;
    logic                inserting;

    tbl_wr_t             wr;
    tbl_rd_t             rd;
    logic [ID_W-1:0]     rd_id;
    logic [SUM_W-1:0]    rd_sum;
    logic [SUM_W-1:0]    alu_acc;
    logic [SUM_W-1:0]    alu_sum;
    logic                alu_clip;

    sra_table u_table (
        .aclk       (aclk),
        .wr         (wr),
        .rd         (rd),
        .rd_id_reg  (rd_id),
        .rd_sum_reg (rd_sum)
    );

    assign alu_acc = (state_reg == FSM_RHS) ? rhs_reg : rd_sum;

    sra_satadd u_satadd (
        .acc     (alu_acc),
        .addend  (addend_reg),
        .sum     (alu_sum),
        .clipped (alu_clip)
    );

    assign s_tready  = state_reg == FSM_IDLE;
    assign accept    = s_tvalid && s_tready;
    assign out_free  = !m_valid_reg || m_tready;
    assign emitting  = pend_reg && out_free;
    assign dump_last = (CNT_W'(pend_idx_reg) + CNT_W'(1)) == fill_reg;
    assign inserting = load && e_status == ST_INSERT;

    always_comb begin
        state_next    = state_reg;
        fill_next     = fill_reg;
        rhs_next      = rhs_reg;
        idx_next      = idx_reg;
        pend_next     = pend_reg;
        pend_idx_next = pend_idx_reg;
        wr            = '0;
        rd            = '0;
        load          = 1'b0;
        e_status      = ST_DONE;
        e_valid       = 1'b0;
        e_id          = '0;
        e_sum         = '0;
        e_sat         = 1'b0;
        e_last        = 1'b1;

        case (state_reg)
            FSM_IDLE: begin
                idx_next  = '0;
                pend_next = 1'b0;
                if (s_tvalid) begin
                    case (s_tuser)
                        ACT_ADD:   state_next = FSM_SEARCH;
                        ACT_RHS:   state_next = FSM_RHS;
                        ACT_CLEAR: state_next = FSM_CLEAR;
                        default:   state_next = FSM_DUMP;
                    endcase
                end
            end
            FSM_SEARCH: begin
                if (pend_reg && rd_id == col_reg) begin
                    state_next = FSM_UPDATE;
                end else if (idx_reg < fill_reg) begin
                    rd.en         = 1'b1;
                    rd.addr       = idx_reg[IDX_W-1:0];
                    pend_next     = 1'b1;
                    pend_idx_next = idx_reg[IDX_W-1:0];
                    idx_next      = idx_reg + CNT_W'(1);
                end else begin
                    state_next = FSM_APPEND;
                end
            end
            FSM_UPDATE: begin
                if (out_free) begin
                    wr.en      = 1'b1;
                    wr.addr    = pend_idx_reg;
                    wr.id      = col_reg;
                    wr.sum     = alu_sum;
                    load       = 1'b1;
                    e_status   = ST_ACCUM;
                    e_sat      = alu_clip;
                    state_next = FSM_IDLE;
                end
            end
            FSM_APPEND: begin
                if (out_free) begin
                    load       = 1'b1;
                    state_next = FSM_IDLE;
                    if (fill_reg == CNT_W'(CAPACITY)) begin
                        e_status = ST_FULL;
                    end else begin
                        wr.en     = 1'b1;
                        wr.addr   = fill_reg[IDX_W-1:0];
                        wr.id     = col_reg;
                        wr.sum    = {{(SUM_W - ADD_W){addend_reg[ADD_W-1]}}, addend_reg};
                        fill_next = fill_reg + CNT_W'(1);
                        e_status  = ST_INSERT;
                    end
                end
            end
            FSM_RHS: begin
                if (out_free) begin
                    rhs_next   = alu_sum;
                    load       = 1'b1;
                    e_sat      = alu_clip;
                    state_next = FSM_IDLE;
                end
            end
            FSM_CLEAR: begin
                if (out_free) begin
                    fill_next  = '0;
                    rhs_next   = '0;
                    load       = 1'b1;
                    state_next = FSM_IDLE;
                end
            end
            FSM_DUMP: begin
                e_status = ST_DUMP;
                if (fill_reg == '0) begin
                    if (out_free) begin
                        load       = 1'b1;
                        state_next = FSM_IDLE;
                    end
                end else begin
                    if (emitting) begin
                        load    = 1'b1;
                        e_valid = 1'b1;
                        e_id    = rd_id;
                        e_sum   = rd_sum;
                        e_last  = dump_last;
                        if (dump_last) begin
                            state_next = FSM_IDLE;
                        end
                    end
                    if ((!pend_reg || emitting) && idx_reg < fill_reg) begin
                        rd.en         = 1'b1;
                        rd.addr       = idx_reg[IDX_W-1:0];
                        pend_next     = 1'b1;
                        pend_idx_next = idx_reg[IDX_W-1:0];
                        idx_next      = idx_reg + CNT_W'(1);
                    end else if (emitting) begin
                        pend_next = 1'b0;
                    end
                end
            end
            default: begin
                state_next = FSM_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next  = m_valid_reg;
        o_status_next = o_status_reg;
        o_valid_next  = o_valid_reg;
        o_id_next     = o_id_reg;
        o_sum_next    = o_sum_reg;
        o_count_next  = o_count_reg;
        o_rhs_next    = o_rhs_reg;
        o_sat_next    = o_sat_reg;
        o_last_next   = o_last_reg;
        if (load) begin
            m_valid_next  = 1'b1;
            o_status_next = e_status;
            o_valid_next  = e_valid;
            o_id_next     = e_id;
            o_sum_next    = e_sum;
            o_count_next  = COUNT_W'(fill_next);
            o_rhs_next    = rhs_next;
            o_sat_next    = e_sat;
            o_last_next   = e_last;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= FSM_IDLE;
            fill_reg    <= '0;
            rhs_reg     <= '0;
            idx_reg     <= '0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            fill_reg    <= fill_next;
            rhs_reg     <= rhs_next;
            idx_reg     <= idx_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            col_reg    <= s_tdata[ID_W-1:0];
            addend_reg <= s_tdata[ID_W +: ADD_W];
        end
        pend_idx_reg <= pend_idx_next;
        o_status_reg <= o_status_next;
        o_valid_reg  <= o_valid_next;
        o_id_reg     <= o_id_next;
        o_sum_reg    <= o_sum_next;
        o_count_reg  <= o_count_next;
        o_rhs_reg    <= o_rhs_next;
        o_sat_reg    <= o_sat_next;
        o_last_reg   <= o_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{M_PAD_W{1'b0}}, o_rhs_reg, o_count_reg, o_sum_reg, o_id_reg};
    assign m_tuser  = {o_sat_reg, o_valid_reg, o_status_reg};
    assign m_tlast  = o_last_reg;

    `SRA_ASSERT_ALWAYS(a_fill_bound, fill_reg <= CNT_W'(CAPACITY))
    `SRA_ASSERT_ALWAYS(a_port_exclusive, !(wr.en && rd.en))
    `SRA_ASSERT_NEXT(a_insert_grows, inserting, fill_reg == $past(fill_reg) + CNT_W'(1))

endmodule
`default_nettype wire

@@ dv/sparse_row_accumulator_tb.sv @@
`timescale 1ns / 1ps
module sparse_row_accumulator_tb;
    import sra_pkg::*;

    localparam int SUM_LSB   = ID_W;
    localparam int COUNT_LSB = SUM_LSB + SUM_W;
    localparam int RHS_LSB   = COUNT_LSB + COUNT_W;
    localparam int PAD_LSB   = RHS_LSB + SUM_W;
    localparam int VALID_BIT = STATUS_W;
    localparam int SAT_BIT   = STATUS_W + 1;

    localparam longint SUM_TOP    = (longint'(1) << (SUM_W - 1)) - 1;
    localparam longint SUM_BOTTOM = -(longint'(1) << (SUM_W - 1));

    localparam logic [ID_W-1:0]  ID_MAX  = '1;
    localparam logic [ADD_W-1:0] ADD_MAX = 32'h7FFF_FFFF;
    localparam logic [ADD_W-1:0] ADD_MIN = 32'h8000_0000;

    localparam int RANDOM_ITEMS = 90;
    localparam int CLIP_STEPS   = 260;

    typedef struct {
        logic [STATUS_W-1:0] status;
        logic                entry_valid;
        logic [ID_W-1:0]     entry_id;
        logic [SUM_W-1:0]    entry_sum;
        logic [COUNT_W-1:0]  entry_count;
        logic [SUM_W-1:0]    rhs_sum;
        logic                saturated;
        logic                last;
    } row_result_t;

    class row_ledger;
        logic [ID_W-1:0] col_ids [CAPACITY];
        longint          col_sums [CAPACITY];
        int              fill;
        longint          rhs;
        row_result_t     pending_results [$];
        int              errors;

        function new();
            fill   = 0;
            rhs    = 0;
            errors = 0;
        endfunction

        function longint clip(input longint sum, output logic sat);
            sat = 1'b0;
            if (sum > SUM_TOP) begin
                sum = SUM_TOP;
                sat = 1'b1;
            end else if (sum < SUM_BOTTOM) begin
                sum = SUM_BOTTOM;
                sat = 1'b1;
            end
            return sum;
        endfunction

        function void post(input logic [STATUS_W-1:0] status, input logic valid,
                           input logic [ID_W-1:0] id, input longint sum,
                           input logic sat, input logic last);
            row_result_t r;
            r.status      = status;
            r.entry_valid = valid;
            r.entry_id    = id;
            r.entry_sum   = SUM_W'(sum);
            r.entry_count = COUNT_W'(fill);
            r.rhs_sum     = SUM_W'(rhs);
            r.saturated   = sat;
            r.last        = last;
            pending_results.push_back(r);
        endfunction

        function void note_request(input logic [ACTION_W-1:0] action,
                                   input logic [ID_W-1:0] col,
                                   input logic signed [ADD_W-1:0] addend);
            longint addend_wide;
            logic   sat;
            int     hit;
            addend_wide = longint'(addend);
            hit = -1;
            case (action)
                ACT_ADD: begin
                    for (int i = 0; i < fill; i++)
                        if (hit < 0 && col_ids[i] == col)
                            hit = i;
                    if (hit >= 0) begin
                        col_sums[hit] = clip(col_sums[hit] + addend_wide, sat);
                        post(ST_ACCUM, 1'b0, '0, 0, sat, 1'b1);
                    end else if (fill >= CAPACITY) begin
                        post(ST_FULL, 1'b0, '0, 0, 1'b0, 1'b1);
                    end else begin
                        col_ids[fill]  = col;
                        col_sums[fill] = addend_wide;
                        fill++;
                        post(ST_INSERT, 1'b0, '0, 0, 1'b0, 1'b1);
                    end
                end
                ACT_RHS: begin
                    rhs = clip(rhs + addend_wide, sat);
                    post(ST_DONE, 1'b0, '0, 0, sat, 1'b1);
                end
                ACT_CLEAR: begin
                    fill = 0;
                    rhs  = 0;
                    post(ST_DONE, 1'b0, '0, 0, 1'b0, 1'b1);
                end
                default: begin
                    if (fill == 0)
                        post(ST_DUMP, 1'b0, '0, 0, 1'b0, 1'b1);
                    else
                        for (int i = 0; i < fill; i++)
                            post(ST_DUMP, 1'b1, col_ids[i], col_sums[i], 1'b0,
                                 i == fill - 1);
                end
            endcase
        endfunction

        task report(input string field, input logic [63:0] got, input logic [63:0] want);
            errors++;
            if (errors <= 40)
                $display("%0t: %s mismatch: got 0x%0h, expected 0x%0h",
                         $time, field, got, want);
        endtask

        task check_result(input logic [M_TDATA_W-1:0] tdata,
                          input logic [M_TUSER_W-1:0] tuser, input logic tlast);
            row_result_t want;
            if (pending_results.size() == 0) begin
                report("unrequested result", tdata[63:0], '0);
                return;
            end
            want = pending_results.pop_front();
            if (tuser[STATUS_W-1:0] != want.status)
                report("status", tuser[STATUS_W-1:0], want.status);
            if (tuser[VALID_BIT] != want.entry_valid)
                report("entry_valid", tuser[VALID_BIT], want.entry_valid);
            if (tuser[SAT_BIT] != want.saturated)
                report("saturated", tuser[SAT_BIT], want.saturated);
            if (tlast != want.last)
                report("last", tlast, want.last);
            if (tdata[ID_W-1:0] != want.entry_id)
                report("entry_id", tdata[ID_W-1:0], want.entry_id);
            if (tdata[SUM_LSB +: SUM_W] != want.entry_sum)
                report("entry_sum", tdata[SUM_LSB +: SUM_W], want.entry_sum);
            if (tdata[COUNT_LSB +: COUNT_W] != want.entry_count)
                report("entry_count", tdata[COUNT_LSB +: COUNT_W], want.entry_count);
            if (tdata[RHS_LSB +: SUM_W] != want.rhs_sum)
                report("rhs_sum", tdata[RHS_LSB +: SUM_W], want.rhs_sum);
            if (tdata[PAD_LSB +: M_PAD_W] != '0)
                report("tdata padding", tdata[PAD_LSB +: M_PAD_W], '0);
        endtask
    endclass

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic [ACTION_W-1:0]  s_tuser = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [M_TUSER_W-1:0] m_tuser;
    logic                 m_tlast;

    row_ledger ledger;
    int        items_sent = 0;
    bit        tx_quiet = 1'b0;
    bit        rx_quiet = 1'b0;
    int        rx_hold = 0;

    sparse_row_accumulator i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #10 aclk = ~aclk;

    function automatic int idle_cycles(input bit quiet);
        int r;
        r = $urandom_range(0, 19);
        if (quiet || r < 11)
            return 0;
        if (r < 18)
            return $urandom_range(1, 3);
        return $urandom_range(12, 40);
    endfunction

    function automatic logic [ID_W-1:0] pick_id();
        int r;
        r = $urandom_range(0, 7);
        if (r == 0)
            return '0;
        if (r == 1)
            return ID_MAX;
        return ID_W'($urandom);
    endfunction

    function automatic logic [ADD_W-1:0] pick_addend();
        int r;
        r = $urandom_range(0, 9);
        case (r)
            0: return ADD_MAX;
            1: return ADD_MIN;
            2: return '0;
            3: return ADD_W'($urandom_range(0, 512) - 256);
            default: return $urandom;
        endcase
    endfunction

    always @(negedge aclk) begin
        if ($urandom_range(0, 299) == 0)
            rx_quiet <= !rx_quiet;
        if (rx_hold != 0) begin
            m_tready <= 1'b0;
            rx_hold  <= rx_hold - 1;
        end else begin
            m_tready <= 1'b1;
            rx_hold  <= idle_cycles(rx_quiet);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            ledger.check_result(m_tdata, m_tuser, m_tlast);
    end

    task automatic send_request(input logic [ACTION_W-1:0] action,
                                input logic [ID_W-1:0] col, input logic [ADD_W-1:0] addend);
        int gap;
        gap = idle_cycles(tx_quiet);
        @(negedge aclk);
        if (gap != 0) begin
            s_tvalid = 1'b0;
            s_tdata  = {$urandom, $urandom};
            s_tuser  = ACTION_W'($urandom);
            repeat (gap) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tuser  = action;
        s_tdata  = {1'b0, addend, col};
        do @(posedge aclk); while (!s_tready);
        ledger.note_request(action, col, addend);
        items_sent++;
    endtask

    task automatic wait_for_results();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (ledger.pending_results.size() != 0)
            @(posedge aclk);
    endtask

    // Clear (mostly), add the first n_ids ids in order, then accumulate at random with rhs adds mixed in; dump.
    task automatic build_row(input int n_adds, input int n_ids);
        logic [ID_W-1:0] ids [$];
        for (int k = 0; k < n_ids; k++)
            ids.push_back(pick_id());
        if ($urandom_range(0, 3) != 0)
            send_request(ACT_CLEAR, pick_id(), $urandom);
        for (int k = 0; k < n_adds; k++) begin
            if ($urandom_range(0, 5) == 0)
                send_request(ACT_RHS, pick_id(), pick_addend());
            else if (k < n_ids)
                send_request(ACT_ADD, ids[k], pick_addend());
            else
                send_request(ACT_ADD, ids[$urandom_range(0, n_ids - 1)], pick_addend());
        end
        send_request(ACT_DUMP, pick_id(), $urandom);
    endtask

    initial begin
        logic [ID_W-1:0] col;
        int              pick;
        int              n_adds;
        int              target;

        ledger = new();
        repeat (12) @(negedge aclk);
        aresetn = 1'b1;

        send_request(ACT_DUMP, '0, '0);
        send_request(ACT_RHS, ID_MAX, ADD_MAX);
        send_request(ACT_RHS, '0, ADD_MIN);
        send_request(ACT_ADD, '0, ADD_MAX);
        send_request(ACT_ADD, ID_MAX, ADD_MIN);
        send_request(ACT_ADD, '0, ADD_MIN);
        send_request(ACT_ADD, ID_MAX, '0);
        send_request(ACT_ADD, 31'h2AAA_AAAA, 32'h5555_5555);
        send_request(ACT_ADD, 31'h5555_5555, 32'hAAAA_AAAA);
        send_request(ACT_ADD, 31'h2AAA_AAAA, 32'hFFFF_FFFF);
        send_request(ACT_DUMP, ID_MAX, '1);
        send_request(ACT_CLEAR, '0, '0);
        send_request(ACT_DUMP, '0, '0);
        send_request(ACT_RHS, '0, 32'h0000_0001);
        send_request(ACT_ADD, 31'd5, 32'hFFFF_FFFF);
        send_request(ACT_DUMP, '0, '0);
        wait_for_results();

        target = items_sent + RANDOM_ITEMS;
        while (items_sent < target) begin
            pick = $urandom_range(0, 11);
            if (pick <= 5) begin
                n_adds = $urandom_range(1, 10);
                build_row(n_adds, $urandom_range(1, n_adds));
            end else if (pick == 6) begin
                pick = $urandom_range(30, 36);
                build_row(pick + $urandom_range(0, 8), pick);
            end else if (pick <= 8) begin
                repeat ($urandom_range(1, 4))
                    send_request(ACTION_W'($urandom), pick_id(), pick_addend());
            end else if (pick == 9) begin
                wait_for_results();
            end else begin
                tx_quiet = ($urandom_range(0, 3) == 0);
            end
        end

        // drive one entry up until it clips, then back off
        tx_quiet = 1'b0;
        col = pick_id();
        send_request(ACT_CLEAR, col, '0);
        for (int k = 0; k < CLIP_STEPS; k++)
            send_request(ACT_ADD, col, ADD_MAX - ADD_W'($urandom_range(0, 65535)));
        send_request(ACT_ADD, col, ADD_MIN);
        send_request(ACT_RHS, col, ADD_MAX);
        send_request(ACT_DUMP, col, '0);

        wait_for_results();
        repeat (40) @(posedge aclk);
        if (ledger.errors == 0 && ledger.pending_results.size() == 0) begin
            $display("sparse_row_accumulator_tb passed");
        end else begin
            $display("sparse_row_accumulator_tb failed");
        end
        $finish;
    end

    initial begin
        #100_000_000;
        $display("sparse_row_accumulator_tb failed");
        $finish;
    end

endmodule
